### hw/rtl/isort_pkg.sv
// isort_pkg: shared types and constants for the insertion sorter
// holds item structs, cell control struct and the sequencer state enum
// no dependencies
package isort_pkg;

  localparam int CAPACITY = 16;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               end_of_list;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic {
    MODE_LOAD,
    MODE_DRAIN
  } mode_t;

endpackage

### hw/rtl/insertion_sorter.sv
// insertion_sorter: top level of the insertion sorter
// a chain of CAPACITY isort_cell slots plus a load/drain sequencer
// depends on isort_pkg and isort_cell
//
// usage:
//   in_valid/in_ready/in_item carry one value per item plus an is_last flag.
//   while loading, one item is taken every cycle; each value is inserted by
//   all cells comparing and shifting in parallel, equal values keep arrival
//   order. values arriving with all CAPACITY slots full are dropped and
//   every result of that list carries overflowed.
//   after the is_last item, the next cycle starts draining: the chain shifts
//   toward cell 0 and out_item shows cell 0 directly from its register, one
//   result per cycle while out_ready is high. end_of_list marks the largest
//   value, and in_ready is low while draining.
//   a stalled receiver simply freezes the chain; nothing is lost.
//   reset clears all valid bits, the drop flag and returns to loading.
module insertion_sorter import isort_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  mode_t                    mode_r;
  mode_t                    mode_nxt;
  logic                     drop_r;
  logic                     drop_nxt;
  logic                     accept;
  logic                     full;
  cell_ctrl_t               ctrl;
  logic signed [31:0]       values [CAPACITY];
  logic [CAPACITY-1:0]      valids;
  logic [CAPACITY-1:0]      gts;

  assign full = valids[CAPACITY-1];

  always_comb begin
    mode_nxt   = mode_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctrl.ins   = 1'b0;
    ctrl.shift = 1'b0;
    unique case (mode_r)
      MODE_LOAD: begin
        in_ready = 1'b1;
        ctrl.ins = in_valid && !full;
        if (in_valid && in_item.is_last) begin
          mode_nxt = MODE_DRAIN;
        end
      end
      MODE_DRAIN: begin
        out_valid  = 1'b1;
        ctrl.shift = out_ready;
        if (out_ready && !valids[1]) begin
          mode_nxt = MODE_LOAD;
        end
      end
      default: begin
        mode_nxt = MODE_LOAD;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    drop_nxt = drop_r;
    if (accept && full) begin
      drop_nxt = 1'b1;
    end else if (mode_r == MODE_DRAIN && out_ready && !valids[1]) begin
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LOAD;
      drop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      drop_r <= drop_nxt;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_chain
      logic signed [31:0] lv;
      logic               lg;
      logic               lvld;
      logic signed [31:0] rv;
      logic               rvld;
      if (i == 0) begin : g_head
        assign lv   = '0;
        assign lg   = 1'b0;
        assign lvld = 1'b1;
      end else begin : g_mid
        assign lv   = values[i-1];
        assign lg   = gts[i-1];
        assign lvld = valids[i-1];
      end
      if (i == CAPACITY-1) begin : g_tail
        assign rv   = '0;
        assign rvld = 1'b0;
      end else begin : g_body
        assign rv   = values[i+1];
        assign rvld = valids[i+1];
      end
      isort_cell u_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .new_value   (in_item.value),
        .left_value  (lv),
        .left_gt     (lg),
        .left_valid  (lvld),
        .right_value (rv),
        .right_valid (rvld),
        .value       (values[i]),
        .valid       (valids[i]),
        .gt          (gts[i])
      );
    end
  endgenerate

  assign out_item.sorted_value = values[0];
  assign out_item.end_of_list  = !valids[1];
  assign out_item.overflowed   = drop_r;

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DRAIN |-> valids[0])
    else $error("draining with empty head slot");

  a_valid_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valids & (valids + 1'b1)) == '0)
    else $error("valid bits not packed toward head");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_LOAD && drop_r) |-> full)
    else $error("drop flag set while chain not full");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.is_last) |=> mode_r == MODE_DRAIN)
    else $error("last item did not start drain");

endmodule

### hw/rtl/isort_cell.sv
// isort_cell: one slot of the insertion chain, holds one value and its valid bit
// compares the broadcast item against its value, shifts up on insert, down on drain
// depends on isort_pkg
module isort_cell import isort_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] new_value,
  input  logic signed [31:0] left_value,
  input  logic               left_gt,
  input  logic               left_valid,
  input  logic signed [31:0] right_value,
  input  logic               right_valid,
  output logic signed [31:0] value,
  output logic               valid,
  output logic               gt
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;
  logic               valid_r;
  logic               valid_nxt;

  assign gt    = valid_r && (value_r > new_value);
  assign value = value_r;
  assign valid = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    priority if (ctrl.ins) begin
      if (left_gt) begin
        value_nxt = left_value;
        valid_nxt = 1'b1;
      end else if ((gt || !valid_r) && left_valid) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.shift) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
